// ===== rtl/core/triangle_face_normal_core_defines.svh =====
// ----------------------------------------------------------------------------
// triangle face normal assertion macros
// shared property forms for the normal core
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_CORE_DEFINES_SVH

// implication checked on every clock, quiet while in reset
`define TFN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// constants and helpers shared by the face normal pipeline
// ----------------------------------------------------------------------------
package tfn_pkg;
    localparam int COORD_WIDTH_DEF      = 24;
    localparam int NORMAL_FRAC_BITS_DEF = 14;
    localparam int OUT_WIDTH            = 16;
    localparam int ALIGN_BITS           = 30;
    // reduced edge component magnitude, below 2^30
    localparam int EW = 31;
    // cross component: two 31-bit products and a difference
    localparam int CW = 62;
    // aligned magnitude, below 2^30
    localparam int MW = 30;
    // sum of three squares below 3*2^60
    localparam int SW = 62;
    localparam int RW = 31;
    localparam int LW = 7;

    // bit length of a 64-bit magnitude
    function automatic logic [LW-1:0] bit_len(input logic [63:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = LW'(i + 1);
        end
        return n;
    endfunction
endpackage

// ===== rtl/core/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// edges, range reduction, cross product and alignment; five stages
// ----------------------------------------------------------------------------
module tfn_cross #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_p [9],
    output logic                          o_vld,
    output logic [tfn_pkg::MW-1:0]        o_mag [3],
    output logic [2:0]                    o_neg,
    output logic                          o_zero
);
    import tfn_pkg::*;
    localparam int DW = COORD_WIDTH + 1;

    logic [4:0] r_vld;
    logic [DW-1:0] r_m1 [3], r_m2 [3];
    logic [2:0] r_s1, r_s2;
    logic signed [EW:0] r_e1 [3], r_e2 [3];
    logic signed [CW-1:0] r_pa [3], r_pb [3];
    logic signed [CW:0]   r_cr [3];
    logic [MW-1:0] r_mag [3];
    logic [2:0] r_neg;
    logic r_zero;

    // magnitude with a wide unsigned result
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // reduce one edge so the largest magnitude is below 2^30
    function automatic void reduce(input logic [DW-1:0] m [3], input logic [2:0] s,
                                   output logic signed [EW:0] e [3]);
        logic [LW-1:0] len;
        logic [LW-1:0] sh;
        logic [63:0] t;
        len = bit_len(64'(m[0] | m[1] | m[2]));
        sh  = (len > LW'(ALIGN_BITS)) ? len - LW'(ALIGN_BITS) : '0;
        for (int i = 0; i < 3; i++) begin
            t = 64'(m[i]) >> sh;
            e[i] = s[i] ? -$signed({1'b0, t[EW-1:0]}) : $signed({1'b0, t[EW-1:0]});
        end
    endfunction

    logic signed [EW:0] n_e1 [3], n_e2 [3];
    always_comb begin
        reduce(r_m1, r_s1, n_e1);
        reduce(r_m2, r_s2, n_e2);
    end

    // alignment of the exact cross product
    logic [63:0] n_cm [3];
    logic [LW-1:0] n_len;
    logic [MW-1:0] n_mag [3];
    always_comb begin
        for (int i = 0; i < 3; i++) n_cm[i] = mag64(64'(r_cr[i]));
        n_len = bit_len(n_cm[0] | n_cm[1] | n_cm[2]);
        for (int i = 0; i < 3; i++) begin
            if (n_len > LW'(ALIGN_BITS))
                n_mag[i] = MW'(n_cm[i] >> (n_len - LW'(ALIGN_BITS)));
            else
                n_mag[i] = MW'(n_cm[i] << (LW'(ALIGN_BITS) - n_len));
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [DW-1:0] d1, d2;
                d1 = DW'(i_p[3+i]) - DW'(i_p[i]);
                d2 = DW'(i_p[6+i]) - DW'(i_p[i]);
                r_s1[i] <= d1[DW-1];
                r_s2[i] <= d2[DW-1];
                r_m1[i] <= d1[DW-1] ? DW'(-d1) : DW'(d1);
                r_m2[i] <= d2[DW-1] ? DW'(-d2) : DW'(d2);
                r_e1[i] <= n_e1[i];
                r_e2[i] <= n_e2[i];
            end
            r_pa[0] <= CW'(r_e1[1] * r_e2[2]);
            r_pb[0] <= CW'(r_e1[2] * r_e2[1]);
            r_pa[1] <= CW'(r_e1[2] * r_e2[0]);
            r_pb[1] <= CW'(r_e1[0] * r_e2[2]);
            r_pa[2] <= CW'(r_e1[0] * r_e2[1]);
            r_pb[2] <= CW'(r_e1[1] * r_e2[0]);
            for (int i = 0; i < 3; i++) begin
                r_cr[i]  <= (CW+1)'(r_pa[i]) - (CW+1)'(r_pb[i]);
                r_mag[i] <= n_mag[i];
                r_neg[i] <= r_cr[i][CW];
            end
            r_zero <= (n_len == '0);
        end
    end

    assign o_vld  = r_vld[4];
    assign o_mag  = r_mag;
    assign o_neg  = r_neg;
    assign o_zero = r_zero;
endmodule

// ===== rtl/core/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// sum of squares then pipelined integer square root, two bits a stage
// ----------------------------------------------------------------------------
module tfn_sqrt #(
    parameter int PW = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [tfn_pkg::MW-1:0] i_mag [3],
    input  logic [PW-1:0]          i_side,
    output logic                   o_vld,
    output logic [tfn_pkg::MW-1:0] o_mag [3],
    output logic [PW-1:0]          o_side,
    output logic [tfn_pkg::RW-1:0] o_root
);
    import tfn_pkg::*;
    localparam int NS = SW / 2;
    localparam int NST = NS / 2;

    // squares then sum
    logic [SW-1:0] r_sq [3];
    logic [SW-1:0] r_sum;
    logic [1:0] r_vin;
    logic [MW-1:0] r_m0 [3], r_m1 [3];
    logic [PW-1:0] r_d0, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vin <= '0;
        else if (i_en) r_vin <= {r_vin[0], i_vld};
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_sq[i] <= SW'(i_mag[i] * i_mag[i]);
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_m0 <= i_mag; r_m1 <= r_m0;
            r_d0 <= i_side; r_d1 <= r_d0;
        end
    end

    // root stages: each resolves two root bits
    logic [SW-1:0] r_rem [NST+1];
    logic [RW-1:0] r_root [NST+1];
    logic [NST:0] r_v;
    logic [MW-1:0] r_mp [NST+1][3];
    logic [PW-1:0] r_dp [NST+1];

    always_comb begin
        r_rem[0]  = r_sum;
        r_root[0] = '0;
        r_v[0]    = r_vin[1];
        r_mp[0]   = r_m1;
        r_dp[0]   = r_d1;
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [SW+1:0] n_rem;
        logic [RW-1:0] n_root;
        always_comb begin
            logic [SW+1:0] trial;
            n_rem  = (SW+2)'(r_rem[g]);
            n_root = r_root[g];
            for (int k = 0; k < 2; k++) begin
                trial = (SW+2)'({n_root, 2'b01}) << (2 * (NS - 1 - (2*g + k)));
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[RW-2:0], 1'b1};
                end else begin
                    n_root = {n_root[RW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g+1] <= 1'b0;
            else if (i_en) r_v[g+1] <= r_v[g];
            if (i_en) begin
                r_rem[g+1]  <= SW'(n_rem);
                r_root[g+1] <= n_root;
                r_mp[g+1]   <= r_mp[g];
                r_dp[g+1]   <= r_dp[g];
            end
        end
    end

    // last odd root bit
    logic [SW+1:0] n_tr;
    logic [RW-1:0] r_fin;
    logic r_fv;
    logic [MW-1:0] r_fm [3];
    logic [PW-1:0] r_fd;
    assign n_tr = (SW+2)'({r_root[NST], 2'b01});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fv <= 1'b0;
        else if (i_en) r_fv <= r_v[NST];
        if (i_en) begin
            r_fin <= ((SW+2)'(r_rem[NST]) >= n_tr) ? {r_root[NST][RW-2:0], 1'b1}
                                                  : {r_root[NST][RW-2:0], 1'b0};
            r_fm <= r_mp[NST];
            r_fd <= r_dp[NST];
        end
    end

    assign o_vld  = r_fv;
    assign o_mag  = r_fm;
    assign o_side = r_fd;
    assign o_root = r_fin;
endmodule

// ===== rtl/core/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// three pipelined restoring dividers, two quotient bits a stage
// ----------------------------------------------------------------------------
module tfn_div #(
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int PW = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [tfn_pkg::MW-1:0] i_mag [3],
    input  logic [PW-1:0]          i_side,
    input  logic [tfn_pkg::RW-1:0] i_root,
    output logic                   o_vld,
    output logic [NORMAL_FRAC_BITS:0] o_q [3],
    output logic [PW-1:0]          o_side
);
    import tfn_pkg::*;
    // quotient never exceeds 2^(F+1) since n >= |c|
    localparam int QB = NORMAL_FRAC_BITS + 2;
    localparam int NW = MW + NORMAL_FRAC_BITS + 1;
    localparam int NST = (QB + 1) / 2;

    logic [NW-1:0] r_num [NST+1][3];
    logic [QB-1:0] r_q [NST+1][3];
    logic [RW-1:0] r_d [NST+1];
    logic [PW-1:0] r_sd [NST+1];
    logic [NST:0]  r_v;

    // dividend with rounding term
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            r_num[0][i] = (NW'(i_mag[i]) << NORMAL_FRAC_BITS) + NW'(i_root >> 1);
            r_q[0][i]   = '0;
        end
        r_d[0]  = i_root;
        r_sd[0] = i_side;
        r_v[0]  = i_vld;
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [NW-1:0] n_num [3];
        logic [QB-1:0] n_q [3];
        always_comb begin
            logic [NW+QB-1:0] t;
            for (int i = 0; i < 3; i++) begin
                n_num[i] = r_num[g][i];
                n_q[i]   = r_q[g][i];
                for (int k = 0; k < 2; k++) begin
                    if (2*g + k < QB) begin
                        t = (NW+QB)'(r_d[g]) << (QB - 1 - (2*g + k));
                        if ((NW+QB)'(n_num[i]) >= t) begin
                            n_num[i] = NW'((NW+QB)'(n_num[i]) - t);
                            n_q[i]   = n_q[i] | (QB'(1) << (QB - 1 - (2*g + k)));
                        end
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[g+1] <= 1'b0;
            else if (i_en) r_v[g+1] <= r_v[g];
            if (i_en) begin
                r_num[g+1] <= n_num;
                r_q[g+1]   <= n_q;
                r_d[g+1]   <= r_d[g];
                r_sd[g+1]  <= r_sd[g];
            end
        end
    end

    // clamp to one
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_q[NST][i] > QB'(1) << NORMAL_FRAC_BITS)
                o_q[i] = (NORMAL_FRAC_BITS+1)'(1) << NORMAL_FRAC_BITS;
            else
                o_q[i] = r_q[NST][i][NORMAL_FRAC_BITS:0];
        end
    end
    assign o_vld  = r_v[NST];
    assign o_side = r_sd[NST];
endmodule

// ===== rtl/core/triangle_face_normal_core.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// unit face normal of a fixed-point triangle, fully pipelined
// ----------------------------------------------------------------------------
// channel   direction   signals
// input     in          i_valid / o_ready, i_a_x .. i_c_z
// output    out         o_valid / i_ready, o_normal_x .. o_degenerate
//
// one triangle per cycle while the output is not stalled; 32 register stages:
// five stages of edge, edge shift, products, cross difference and alignment,
// two of squares and sum, fifteen square root stages plus one for the last
// root bit, eight of division, one output register.
// the whole pipeline advances when the output register is free or taken.
// a stall freezes every stage; nothing is dropped or repeated.
// reset clears only valid bits.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_core_defines.svh"
module triangle_face_normal_core #(
    parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_z,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_z,
    input  logic signed [COORD_WIDTH-1:0] i_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_c_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_x,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_y,
    output logic signed [tfn_pkg::OUT_WIDTH-1:0] o_normal_z,
    output logic                          o_degenerate
);
    import tfn_pkg::*;
    localparam int PW = 4;

    logic w_en;
    logic signed [COORD_WIDTH-1:0] w_p [9];
    logic w_cv, w_cz;
    logic [MW-1:0] w_cm [3];
    logic [2:0] w_cn;
    logic w_sv;
    logic [MW-1:0] w_sm [3];
    logic [PW-1:0] w_ss;
    logic [RW-1:0] w_root;
    logic w_dv;
    logic [NORMAL_FRAC_BITS:0] w_q [3];
    logic [PW-1:0] w_ds;
    logic r_valid;
    logic [OUT_WIDTH-1:0] r_n [3];
    logic r_deg;

    // pipeline advances when output slot is free or being drained
    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    assign w_p = '{i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z};

    tfn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(i_valid),
        .i_p(w_p), .o_vld(w_cv), .o_mag(w_cm), .o_neg(w_cn), .o_zero(w_cz)
    );

    tfn_sqrt #(.PW(PW)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_cv),
        .i_mag(w_cm), .i_side({w_cz, w_cn}), .o_vld(w_sv), .o_mag(w_sm),
        .o_side(w_ss), .o_root(w_root)
    );

    tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS), .PW(PW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(w_sv),
        .i_mag(w_sm), .i_side(w_ss), .i_root(w_root | RW'(w_ss[3])),
        .o_vld(w_dv), .o_q(w_q), .o_side(w_ds)
    );

    // output register, signs applied
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_dv;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [OUT_WIDTH-1:0] m;
                m = w_ds[3] ? '0 : OUT_WIDTH'(w_q[i]);
                r_n[i] <= w_ds[i] ? OUT_WIDTH'(-m) : m;
            end
            r_deg <= w_ds[3];
        end
    end

    assign o_valid      = r_valid;
    assign o_normal_x   = r_n[0];
    assign o_normal_y   = r_n[1];
    assign o_normal_z   = r_n[2];
    assign o_degenerate = r_deg;

    `TFN_ASSERT_IMP(a_deg_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_normal_x == 0 && o_normal_y == 0 && o_normal_z == 0, "degenerate result with nonzero normal")
    `TFN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_normal_x) && $stable(o_degenerate), "stalled result changed")
    `TFN_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_valid, o_ready, "pipeline stalled with empty output")
endmodule

// ===== test/triangle_face_normal_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_face_normal_core_tb
// streams triangles through the face normal core and checks every normal
// against an integer model of edge, cross product, rescale, root and divide,
// under random idling on both channels
// ----------------------------------------------------------------------------
module triangle_face_normal_core_tb;
    import tfn_pkg::*;

    localparam int CWID  = COORD_WIDTH_DEF;
    localparam int FRAC  = NORMAL_FRAC_BITS_DEF;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } t_normal;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [CWID-1:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [CWID-1:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [CWID-1:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OUT_WIDTH-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;

    t_normal expected_normals[$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      fail_count = 0;
    int      tri_count = 0;
    int      normal_count = 0;
    int      degen_count = 0;
    int      cycle_count = 0;

    triangle_face_normal_core dut (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic int blen(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    // shift an edge so its largest magnitude fits in 30 bits
    function automatic void shrink_edge(ref longint e[3]);
        int l;
        l = blen(mag(e[0]) | mag(e[1]) | mag(e[2]));
        if (l > ALIGN_BITS) begin
            for (int i = 0; i < 3; i++)
                e[i] = (e[i] < 0) ? -longint'(mag(e[i]) >> (l - ALIGN_BITS))
                                  : longint'(mag(e[i]) >> (l - ALIGN_BITS));
        end
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s = s - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic t_normal face_normal(input logic [CWID-1:0] v[9]);
        longint      p[9], e1[3], e2[3], cr[3];
        logic [63:0] m[3], s, n, q, lim;
        int          l;
        t_normal     r;
        for (int i = 0; i < 9; i++) p[i] = longint'(signed'(v[i]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
        end
        shrink_edge(e1);
        shrink_edge(e2);
        cr[0] = e1[1]*e2[2] - e1[2]*e2[1];
        cr[1] = e1[2]*e2[0] - e1[0]*e2[2];
        cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
        for (int i = 0; i < 3; i++) m[i] = mag(cr[i]);
        l = blen(m[0] | m[1] | m[2]);
        r = '0;
        if (l == 0) begin
            r.degen = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
            m[i] = (l > ALIGN_BITS) ? m[i] >> (l - ALIGN_BITS) : m[i] << (ALIGN_BITS - l);
        s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        n = int_sqrt(s);
        lim = 64'd1 << FRAC;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + (n >> 1)) / n;
            if (q > lim) q = lim;
            q = (cr[i] < 0) ? -q : q;
            if (i == 0) r.nx = q[15:0];
            else if (i == 1) r.ny = q[15:0];
            else r.nz = q[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        $display("mismatch %s at normal %0d: got %h expected %h",
                 what, normal_count, got, want);
    endtask

    // output side: random stall and result check
    always @(negedge i_clk)
        i_ready <= i_rst_n && ($urandom_range(99, 0) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected transfer", o_normal_x, 16'h0000);
            end else begin
                want = expected_normals.pop_front();
                if (o_normal_x !== want.nx) report_mismatch("x", o_normal_x, want.nx);
                if (o_normal_y !== want.ny) report_mismatch("y", o_normal_y, want.ny);
                if (o_normal_z !== want.nz) report_mismatch("z", o_normal_z, want.nz);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", 16'(o_degenerate), 16'(want.degen));
            end
            normal_count++;
        end
    end

    // one triangle transfer; inputs change on the falling edge
    task automatic send_triangle(input logic [CWID-1:0] v[9]);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z}
            <= {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_normals.insert(expected_normals.size(), face_normal(v));
        if (face_normal(v).degen) degen_count++;
        tri_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [CWID-1:0] rand_coord(input int bits);
        logic [31:0] r;
        r = $urandom();
        if (bits < CWID) begin
            r = r & ((32'd1 << bits) - 32'd1);
            r = r - (32'd1 << (bits - 1));
        end
        return r[CWID-1:0];
    endfunction

    task automatic test_directed();
        logic [CWID-1:0] v[9];
        logic [CWID-1:0] mx, mn;
        mx = {1'b0, {(CWID-1){1'b1}}};
        mn = {1'b1, {(CWID-1){1'b0}}};
        // unit right triangle in each plane
        v = '{0, 0, 0, 256, 0, 0, 0, 256, 0}; send_triangle(v);
        v = '{0, 0, 0, 0, 256, 0, 0, 0, 256}; send_triangle(v);
        v = '{0, 0, 0, 0, 0, 256, 256, 0, 0}; send_triangle(v);
        // reversed winding
        v = '{0, 0, 0, 0, 256, 0, 256, 0, 0}; send_triangle(v);
        // degenerate: all equal, collinear, all equal at the maximum
        v = '{5, 5, 5, 5, 5, 5, 5, 5, 5}; send_triangle(v);
        v = '{0, 0, 0, 1, 2, 3, 2, 4, 6}; send_triangle(v);
        v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; send_triangle(v);
        // extremes, widest edges
        v = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; send_triangle(v);
        v = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; send_triangle(v);
        v = '{mn, mx, mn, mx, mn, mx, mx, mx, mn}; send_triangle(v);
        v = '{mx, mn, 0, mn, mx, 0, mx, mx, mx}; send_triangle(v);
        // all ones bits and unit edges, then a diagonal normal
        v = '{'1, '1, '1, 0, '1, '1, '1, 0, '1}; send_triangle(v);
        v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
        v = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; send_triangle(v);
        // tiny wide mix: one long edge and one short, then two long edges differing by one
        v = '{0, 0, 0, mx, 0, 0, 0, 1, 0}; send_triangle(v);
        v = '{0, 0, 0, mx, mx, 0, mx, mx, 1}; send_triangle(v);
    endtask

    task automatic test_random(input int count);
        logic [CWID-1:0] v[9];
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(9, 0);
            for (int i = 0; i < 9; i++)
                v[i] = rand_coord((kind < 4) ? CWID : $urandom_range(CWID, 2));
            if (kind == 9) begin
                // repeated vertex: third equals second
                for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
            end
            send_triangle(v);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_normals.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 12; recv_idle_pct = 45;
        test_directed();
        test_random(370);
        send_idle_pct = 45; recv_idle_pct = 12;
        test_random(370);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(390);
        drain();
        $display("sent %0d triangles, checked %0d normals, %0d degenerate",
                 tri_count, normal_count, degen_count);
        $display("phases: sender idle 12%%/receiver 45%%, swapped, then none");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
